[src/iee_pkg.sv]
// ============================================================================
// iee_pkg
// Shared types and constants of the infix expression evaluator.
// ============================================================================
package iee_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd1,
      OP_MUL  = 2'd2,
      OP_OPEN = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNKNOWN   = 2'd1,
      ST_MALFORMED = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_FREAD,
      S_FEXEC
   } state_type;

   typedef struct packed {
      logic             rd_en;
      logic [PTR_W-1:0] rd_top_addr;
      logic [PTR_W-1:0] rd_next_addr;
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
   } vs_ctrl_type;

   function automatic logic [1:0] rank_of(input op_type op);
      logic [1:0] r;
      case (op)
         OP_MUL:  r = 2'd2;
         OP_ADD:  r = 2'd1;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

[src/iee_value_stack.sv]
// ============================================================================
// iee_value_stack
// Value stack memory with one write port and two registered read ports.
// ============================================================================
module iee_value_stack (
   input  logic                              clock,
   input  iee_pkg::vs_ctrl_type              ctrl,
   input  logic [iee_pkg::VALUE_WIDTH-1:0]   wr_data,
   output logic [iee_pkg::VALUE_WIDTH-1:0]   rd_top,
   output logic [iee_pkg::VALUE_WIDTH-1:0]   rd_next
);

   logic [iee_pkg::VALUE_WIDTH-1:0] mem [iee_pkg::STACK_DEPTH];
   logic [iee_pkg::VALUE_WIDTH-1:0] rd_top_ff;
   logic [iee_pkg::VALUE_WIDTH-1:0] rd_next_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_top_ff  <= mem[ctrl.rd_top_addr];
         rd_next_ff <= mem[ctrl.rd_next_addr];
      end
   end

   assign rd_top  = rd_top_ff;
   assign rd_next = rd_next_ff;

endmodule

[src/infix_expression_evaluator.sv]
// ============================================================================
// infix_expression_evaluator
// Evaluates an infix expression of digits, '+', '*' and parentheses that
// arrives one character per request, with an operator and a value stack.
// ============================================================================
// Each character passes through acceptance, a stack read and the update.
// Once an error has been flagged, the characters that follow only pass
// through acceptance. Every operator that a character or the end of the
// expression pops adds a read of the stack memories and a step that applies
// it and writes back. After the last character the stacks are read and each
// remaining operator is applied in turn before the result is registered. A
// result that has not yet been taken holds the finish step of the next
// expression. A new expression may already be accepted while a result waits.
module infix_expression_evaluator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] value, [33:32] status, [39:34] zero
);

   localparam int CW = iee_pkg::CNT_W;
   localparam int PW = iee_pkg::PTR_W;
   localparam int VW = iee_pkg::VALUE_WIDTH;

   iee_pkg::state_type  state_ff, state_in;
   iee_pkg::status_type err_ff, err_in;
   logic [CW-1:0]       opcnt_ff, opcnt_in;
   logic [CW-1:0]       valcnt_ff, valcnt_in;
   logic [7:0]          sym_ff;
   logic                last_ff;

   iee_pkg::op_type     op_mem [iee_pkg::STACK_DEPTH];
   iee_pkg::op_type     op_top_ff;
   iee_pkg::op_type     op_wdata;
   iee_pkg::op_type     cur_op;
   logic                op_we;
   logic [PW-1:0]       op_waddr;

   iee_pkg::vs_ctrl_type vs_ctrl;
   logic [VW-1:0]        vs_wdata;
   logic [VW-1:0]        val_top;
   logic [VW-1:0]        val_next;
   logic [VW-1:0]        apply_res;

   logic [CW-1:0]        opcnt_m1;
   logic [CW-1:0]        valcnt_m1;
   logic [CW-1:0]        valcnt_m2;
   logic                 pop_ok;
   logic                 accept;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_load;
   logic [VW-1:0]           rsp_value_ff, rsp_value_in;
   iee_pkg::status_type     rsp_status_ff, rsp_status_in;

   assign accept    = req_tvalid && req_tready;
   assign opcnt_m1  = CW'(opcnt_ff - CW'(1));
   assign valcnt_m1 = CW'(valcnt_ff - CW'(1));
   assign valcnt_m2 = CW'(valcnt_ff - CW'(2));
   assign pop_ok    = (opcnt_ff != '0) && (op_top_ff != iee_pkg::OP_OPEN);
   assign cur_op    = (sym_ff == iee_pkg::CH_STAR) ? iee_pkg::OP_MUL : iee_pkg::OP_ADD;
   assign apply_res = (op_top_ff == iee_pkg::OP_MUL) ? val_next * val_top
                                                     : val_next + val_top;

   iee_value_stack u_value_stack (
      .clock   (clock),
      .ctrl    (vs_ctrl),
      .wr_data (vs_wdata),
      .rd_top  (val_top),
      .rd_next (val_next)
   );

   always_ff @(posedge clock) begin
      if (op_we) begin
         op_mem[op_waddr] <= op_wdata;
      end
      if (vs_ctrl.rd_en) begin
         op_top_ff <= op_mem[opcnt_m1[PW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iee_pkg::S_IDLE;
         err_ff       <= iee_pkg::ST_OK;
         opcnt_ff     <= '0;
         valcnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         err_ff       <= err_in;
         opcnt_ff     <= opcnt_in;
         valcnt_ff    <= valcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sym_ff  <= req_tdata;
         last_ff <= req_tlast;
      end
      if (rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   always_comb begin
      state_in              = state_ff;
      err_in                = err_ff;
      opcnt_in              = opcnt_ff;
      valcnt_in             = valcnt_ff;
      req_tready            = 1'b0;
      op_we                 = 1'b0;
      op_waddr              = opcnt_ff[PW-1:0];
      op_wdata              = cur_op;
      vs_ctrl.rd_en         = 1'b0;
      vs_ctrl.rd_top_addr   = valcnt_m1[PW-1:0];
      vs_ctrl.rd_next_addr  = valcnt_m2[PW-1:0];
      vs_ctrl.wr_en         = 1'b0;
      vs_ctrl.wr_addr       = valcnt_ff[PW-1:0];
      vs_wdata              = VW'(sym_ff - iee_pkg::CH_ZERO);
      rsp_load              = 1'b0;
      rsp_value_in          = '0;
      rsp_status_in         = err_ff;

      case (state_ff)
         iee_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (err_ff != iee_pkg::ST_OK) begin
                  state_in = req_tlast ? iee_pkg::S_FREAD : iee_pkg::S_IDLE;
               end else begin
                  state_in = iee_pkg::S_READ;
               end
            end
         end

         iee_pkg::S_READ: begin
            vs_ctrl.rd_en = 1'b1;
            state_in      = iee_pkg::S_EXEC;
         end

         iee_pkg::S_EXEC: begin
            state_in = last_ff ? iee_pkg::S_FREAD : iee_pkg::S_IDLE;
            case (sym_ff) inside
               [iee_pkg::CH_ZERO:iee_pkg::CH_NINE]: begin
                  if (valcnt_ff == CW'(iee_pkg::STACK_DEPTH)) begin
                     err_in = iee_pkg::ST_OVERFLOW;
                  end else begin
                     vs_ctrl.wr_en = 1'b1;
                     valcnt_in     = CW'(valcnt_ff + CW'(1));
                  end
               end
               iee_pkg::CH_OPEN: begin
                  if (opcnt_ff == CW'(iee_pkg::STACK_DEPTH)) begin
                     err_in = iee_pkg::ST_OVERFLOW;
                  end else begin
                     op_we    = 1'b1;
                     op_wdata = iee_pkg::OP_OPEN;
                     opcnt_in = CW'(opcnt_ff + CW'(1));
                  end
               end
               iee_pkg::CH_CLOSE, iee_pkg::CH_PLUS, iee_pkg::CH_STAR: begin
                  if (pop_ok && (sym_ff == iee_pkg::CH_CLOSE ||
                      iee_pkg::rank_of(op_top_ff) >= iee_pkg::rank_of(cur_op))) begin
                     opcnt_in = opcnt_m1;
                     if (valcnt_ff < CW'(2)) begin
                        err_in = iee_pkg::ST_MALFORMED;
                     end else begin
                        vs_ctrl.wr_en   = 1'b1;
                        vs_ctrl.wr_addr = valcnt_m2[PW-1:0];
                        vs_wdata        = apply_res;
                        valcnt_in       = valcnt_m1;
                        state_in        = iee_pkg::S_READ;
                     end
                  end else if (sym_ff == iee_pkg::CH_CLOSE) begin
                     if (opcnt_ff == '0) begin
                        err_in = iee_pkg::ST_MALFORMED;
                     end else begin
                        opcnt_in = opcnt_m1;
                     end
                  end else if (opcnt_ff == CW'(iee_pkg::STACK_DEPTH)) begin
                     err_in = iee_pkg::ST_OVERFLOW;
                  end else begin
                     op_we    = 1'b1;
                     opcnt_in = CW'(opcnt_ff + CW'(1));
                  end
               end
               default: begin
                  err_in = iee_pkg::ST_UNKNOWN;
               end
            endcase
         end

         iee_pkg::S_FREAD: begin
            vs_ctrl.rd_en = 1'b1;
            state_in      = iee_pkg::S_FEXEC;
         end

         iee_pkg::S_FEXEC: begin
            if (err_ff == iee_pkg::ST_OK && opcnt_ff != '0) begin
               state_in = iee_pkg::S_FREAD;
               opcnt_in = opcnt_m1;
               if (op_top_ff == iee_pkg::OP_OPEN || valcnt_ff < CW'(2)) begin
                  err_in = iee_pkg::ST_MALFORMED;
               end else begin
                  vs_ctrl.wr_en   = 1'b1;
                  vs_ctrl.wr_addr = valcnt_m2[PW-1:0];
                  vs_wdata        = apply_res;
                  valcnt_in       = valcnt_m1;
               end
            end else begin
               if (err_ff == iee_pkg::ST_OK && valcnt_ff != CW'(1)) begin
                  rsp_status_in = iee_pkg::ST_MALFORMED;
               end
               rsp_value_in = (rsp_status_in == iee_pkg::ST_OK) ? val_top : '0;
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_load  = 1'b1;
                  err_in    = iee_pkg::ST_OK;
                  opcnt_in  = '0;
                  valcnt_in = '0;
                  state_in  = iee_pkg::S_IDLE;
               end
            end
         end

         default: begin
            state_in = iee_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {6'd0, rsp_status_ff, rsp_value_ff[31:0]};

endmodule

[bench/tb_infix_expression_evaluator.sv]
// ============================================================================
// tb_infix_expression_evaluator
// Sends infix expressions character by character, mirrors the operator and
// value stacks in a predictor and checks each result value and status.
// ============================================================================
module tb_infix_expression_evaluator;

   typedef struct {
      logic [7:0] symbol;
      logic       last;
      bit         drain_first;
   } symbol_item_type;

   typedef struct {
      logic [31:0]         value;
      iee_pkg::status_type status;
   } eval_result_type;

   localparam logic [7:0] PUNCT [4] = '{iee_pkg::CH_PLUS, iee_pkg::CH_STAR,
                                        iee_pkg::CH_OPEN, iee_pkg::CH_CLOSE};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;    // [7:0] symbol
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // [31:0] value, [33:32] status, [39:34] zero

   symbol_item_type symbol_queue[$];
   symbol_item_type next_symbol;
   eval_result_type expected_values[$];
   logic [7:0]      expr_buf[$];
   int              mismatch_count = 0;
   int              send_gap = 0;
   int              send_calm = 0;
   int              take_gap = 0;
   int              take_calm = 0;

   // Predictor state.
   iee_pkg::op_type                 op_stack  [iee_pkg::STACK_DEPTH];
   logic [iee_pkg::VALUE_WIDTH-1:0] val_stack [iee_pkg::STACK_DEPTH];
   int                              op_depth  = 0;
   int                              val_depth = 0;
   iee_pkg::status_type             fault     = iee_pkg::ST_OK;

   infix_expression_evaluator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic void add_char(logic [7:0] c);
      expr_buf.insert(expr_buf.size(), c);
   endfunction

   function automatic void note_fault(iee_pkg::status_type s);
      if (fault == iee_pkg::ST_OK) fault = s;
   endfunction

   function automatic void push_val(logic [iee_pkg::VALUE_WIDTH-1:0] v);
      if (val_depth >= iee_pkg::STACK_DEPTH) begin
         note_fault(iee_pkg::ST_OVERFLOW);
      end else begin
         val_stack[val_depth] = v;
         val_depth++;
      end
   endfunction

   function automatic void push_op(iee_pkg::op_type o);
      if (op_depth >= iee_pkg::STACK_DEPTH) begin
         note_fault(iee_pkg::ST_OVERFLOW);
      end else begin
         op_stack[op_depth] = o;
         op_depth++;
      end
   endfunction

   function automatic void reduce(iee_pkg::op_type o);
      logic [iee_pkg::VALUE_WIDTH-1:0] lhs;
      logic [iee_pkg::VALUE_WIDTH-1:0] rhs;
      if (val_depth < 2) begin
         note_fault(iee_pkg::ST_MALFORMED);
         return;
      end
      rhs = val_stack[val_depth-1];
      lhs = val_stack[val_depth-2];
      val_depth -= 2;
      if (o == iee_pkg::OP_MUL) push_val(lhs * rhs);
      else push_val(lhs + rhs);
   endfunction

   function automatic void take_symbol(logic [7:0] c);
      iee_pkg::op_type cur;
      if (c >= iee_pkg::CH_ZERO && c <= iee_pkg::CH_NINE) begin
         push_val(32'(c - iee_pkg::CH_ZERO));
      end else if (c == iee_pkg::CH_OPEN) begin
         push_op(iee_pkg::OP_OPEN);
      end else if (c == iee_pkg::CH_CLOSE) begin
         while (fault == iee_pkg::ST_OK && op_depth > 0 &&
                op_stack[op_depth-1] != iee_pkg::OP_OPEN) begin
            op_depth--;
            reduce(op_stack[op_depth]);
         end
         if (fault != iee_pkg::ST_OK) return;
         if (op_depth == 0) note_fault(iee_pkg::ST_MALFORMED);
         else op_depth--;
      end else if (c == iee_pkg::CH_PLUS || c == iee_pkg::CH_STAR) begin
         cur = (c == iee_pkg::CH_STAR) ? iee_pkg::OP_MUL : iee_pkg::OP_ADD;
         // A stacked operator is popped unless it binds looser than the new one.
         while (fault == iee_pkg::ST_OK && op_depth > 0 &&
                op_stack[op_depth-1] != iee_pkg::OP_OPEN &&
                (op_stack[op_depth-1] == iee_pkg::OP_MUL || cur == iee_pkg::OP_ADD)) begin
            op_depth--;
            reduce(op_stack[op_depth]);
         end
         if (fault == iee_pkg::ST_OK) push_op(cur);
      end else begin
         note_fault(iee_pkg::ST_UNKNOWN);
      end
   endfunction

   function automatic void evaluate_symbol(logic [7:0] c, logic is_last);
      eval_result_type res;
      if (fault == iee_pkg::ST_OK) take_symbol(c);
      if (!is_last) return;
      while (fault == iee_pkg::ST_OK && op_depth > 0) begin
         op_depth--;
         if (op_stack[op_depth] == iee_pkg::OP_OPEN) note_fault(iee_pkg::ST_MALFORMED);
         else reduce(op_stack[op_depth]);
      end
      if (fault == iee_pkg::ST_OK && val_depth != 1) note_fault(iee_pkg::ST_MALFORMED);
      res.value  = (fault == iee_pkg::ST_OK) ? 32'(val_stack[0]) : 32'd0;
      res.status = fault;
      expected_values.insert(expected_values.size(), res);
      op_depth  = 0;
      val_depth = 0;
      fault     = iee_pkg::ST_OK;
   endfunction

   function automatic void check_result(logic [39:0] data);
      eval_result_type want;
      if (expected_values.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual value %h status %0d",
                  $time, data[31:0], data[33:32]);
         mismatch_count++;
         return;
      end
      want = expected_values.pop_front();
      if (data[31:0] !== want.value) begin
         $display("%0t: value mismatch, expected %h actual %h", $time, want.value,
                  data[31:0]);
         mismatch_count++;
      end
      if (data[33:32] !== want.status) begin
         $display("%0t: status mismatch, expected %0d actual %0d", $time, want.status,
                  data[33:32]);
         mismatch_count++;
      end
   endfunction

   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic void append_text(string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endfunction

   function automatic void append_repeat(logic [7:0] c, int n);
      for (int i = 0; i < n; i++) add_char(c);
   endfunction

   function automatic void queue_expression(bit drain);
      symbol_item_type it;
      for (int i = 0; i < expr_buf.size(); i++) begin
         it.symbol      = expr_buf[i];
         it.last        = (i == expr_buf.size() - 1);
         it.drain_first = drain && (i == 0);
         symbol_queue.insert(symbol_queue.size(), it);
      end
      expr_buf.delete();
   endfunction

   function automatic void send_text(string s);
      append_text(s);
      queue_expression(1'b0);
   endfunction

   function automatic void gen_atom(int depth);
      if (depth > 0 && $urandom_range(0, 3) == 0) begin
         add_char(iee_pkg::CH_OPEN);
         gen_sum(depth - 1);
         add_char(iee_pkg::CH_CLOSE);
      end else begin
         add_char(8'(iee_pkg::CH_ZERO + $urandom_range(0, 9)));
      end
   endfunction

   function automatic void gen_product(int depth);
      int factors;
      factors = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 4) : 1;
      for (int f = 0; f < factors; f++) begin
         if (f > 0) add_char(iee_pkg::CH_STAR);
         gen_atom(depth);
      end
   endfunction

   function automatic void gen_sum(int depth);
      int terms;
      terms = $urandom_range(1, 3);
      for (int t = 0; t < terms; t++) begin
         if (t > 0) add_char(iee_pkg::CH_PLUS);
         gen_product(depth);
      end
   endfunction

   function automatic void corrupt_expression();
      int pos;
      pos = $urandom_range(0, expr_buf.size() - 1);
      case ($urandom_range(0, 4))
         0: expr_buf[pos] = 8'($urandom_range(0, 255));
         1: if (expr_buf.size() > 1) expr_buf.delete(pos);
         2: expr_buf.insert(pos, PUNCT[$urandom_range(0, 3)]);
         3: add_char(iee_pkg::CH_CLOSE);
         default: expr_buf.push_front(iee_pkg::CH_OPEN);
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tlast  <= 1'b0;
         send_gap    = 0;
      end else begin
         if (req_tvalid && req_tready) evaluate_symbol(req_tdata, req_tlast);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (symbol_queue.size() > 0 &&
                         !(symbol_queue[0].drain_first && expected_values.size() > 0)) begin
               next_symbol = symbol_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_symbol.symbol;
               req_tlast  <= next_symbol.last;
               send_gap    = pick_gap(send_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         take_gap    = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (take_gap == 0 && $urandom_range(0, 2) == 0) take_gap = pick_gap(take_calm);
         if (take_gap > 0) begin
            take_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int kind;
      int n;

      // Directed expressions.
      send_text("0");
      send_text("9");
      send_text("1+2*3");
      send_text("(1+2)*3");
      send_text("1+2+3*4*5+6");
      send_text("(((1+2)*(3+4))*5+6)");
      append_repeat(iee_pkg::CH_NINE, 1);
      for (int i = 0; i < 10; i++) append_text("*9");
      queue_expression(1'b0);
      send_text("1-2");
      send_text("8/2");
      append_text("3");
      add_char(8'h00);
      queue_expression(1'b0);
      add_char(8'hFF);
      queue_expression(1'b0);
      send_text(": ");
      send_text("12");
      send_text("+");
      send_text("1+");
      send_text("*1");
      send_text("1)");
      send_text("(1");
      send_text("()");
      send_text("1+)");
      send_text("1-)");
      send_text("1)x");
      // Operator stack filled exactly, then one level too deep.
      append_repeat(iee_pkg::CH_OPEN, iee_pkg::STACK_DEPTH);
      append_text("1");
      append_repeat(iee_pkg::CH_CLOSE, iee_pkg::STACK_DEPTH);
      queue_expression(1'b0);
      append_repeat(iee_pkg::CH_OPEN, iee_pkg::STACK_DEPTH + 1);
      append_text("1");
      append_repeat(iee_pkg::CH_CLOSE, iee_pkg::STACK_DEPTH + 1);
      queue_expression(1'b0);
      // Value stack filled exactly, then one digit too many.
      append_repeat(iee_pkg::CH_ZERO + 8'd1, iee_pkg::STACK_DEPTH);
      queue_expression(1'b1);
      append_repeat(iee_pkg::CH_ZERO + 8'd7, iee_pkg::STACK_DEPTH + 1);
      queue_expression(1'b0);

      // Random expressions, mostly well formed.
      while (symbol_queue.size() < 1250) begin
         kind = $urandom_range(0, 99);
         if (kind < 4) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) add_char(8'($urandom_range(0, 255)));
         end else if (kind < 5) begin
            n = $urandom_range(iee_pkg::STACK_DEPTH - 2, iee_pkg::STACK_DEPTH + 2);
            if ($urandom_range(0, 1) == 0) begin
               append_repeat(iee_pkg::CH_OPEN, n);
               gen_sum(1);
               append_repeat(iee_pkg::CH_CLOSE, n);
            end else begin
               for (int i = 0; i < n; i++) begin
                  add_char(8'(iee_pkg::CH_ZERO + $urandom_range(0, 9)));
               end
            end
         end else if (kind < 8) begin
            n = $urandom_range(8, 16);
            for (int i = 0; i < n; i++) begin
               if (i > 0) add_char(iee_pkg::CH_STAR);
               add_char(8'(iee_pkg::CH_ZERO + $urandom_range(5, 9)));
            end
         end else begin
            gen_sum($urandom_range(0, 3));
            if (kind < 30) corrupt_expression();
         end
         queue_expression($urandom_range(0, 39) == 0);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (symbol_queue.size() > 0 || req_tvalid || expected_values.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #12000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
